### rtl/core/gradient_noise_3d_assert.svh
// Assertion macros shared by the gradient noise core.
`ifndef GRADIENT_NOISE_3D_ASSERT_SVH
`define GRADIENT_NOISE_3D_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define GN3_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define GN3_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/gn3_pkg.sv
package gn3_pkg;

  localparam int COORD_W       = 24;
  localparam int NOISE_W       = 18;
  localparam int FRAC_BITS_DEF = 16;
  localparam int OUT_MAX       = 131071;
  localparam int OUT_MIN       = -131072;

  // Permutation of 0..255; index modulo 256 stands in for the doubled table.
  localparam logic [7:0] PERM_ROM [256] = '{
    8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
    8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
    8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
    8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
    8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
    8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
    8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
    8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
    8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
    8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
    8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
    8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
    8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
    8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
    8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
    8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
    8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
    8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
    8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
    8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
    8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
    8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
    8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
    8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
    8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
    8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
    8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
    8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
    8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
    8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
    8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
    8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
  };

endpackage

### rtl/core/gn3_if.sv
interface gn3_in_if;
  logic                        valid;
  logic                        ready;
  logic [gn3_pkg::COORD_W-1:0] x_coord;
  logic [gn3_pkg::COORD_W-1:0] y_coord;
  logic [gn3_pkg::COORD_W-1:0] z_coord;
  modport source (output valid, x_coord, y_coord, z_coord, input ready);
  modport sink   (input valid, x_coord, y_coord, z_coord, output ready);
endinterface

interface gn3_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [gn3_pkg::NOISE_W-1:0] noise_value;
  modport source (output valid, noise_value, input ready);
  modport sink   (input valid, noise_value, output ready);
endinterface

### rtl/core/gradient_noise_3d.sv
// Improved Perlin gradient noise in 3-D, fixed point, as a six-stage pipeline. One item (a point
// with 8 integer and FRAC_BITS fraction bits per axis) enters every cycle unless the pipe is
// full and stalled; its saturated 18-bit noise value leaves stage 6. Each stage holds on its
// own when the stage after it stalls, so bubbles close up and the input takes items while a
// result waits, until all are full. The depth is set by three dependent permutation ROM reads
// of the corner hash beside three dependent fade multiplies, then three trilinear blend levels.
`include "gradient_noise_3d_assert.svh"

module gradient_noise_3d #(
  parameter int FRAC_BITS = gn3_pkg::FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  gn3_in_if.sink    in_if,
  gn3_out_if.source out_if
);

  localparam int NS = 6;            // pipeline stages
  localparam int F  = FRAC_BITS;
  localparam int PW = 2 * F + 8;    // working width of products
  localparam int DW = F + 3;        // dot products and blends
  localparam int SW = F + 5;        // fade polynomial term

  localparam logic signed [PW-1:0] ONE_P  = PW'(1) <<< F;
  localparam logic signed [PW-1:0] HALF_P = PW'(1) <<< (F - 1);
  localparam logic signed [PW-1:0] MAX_P  = PW'(gn3_pkg::OUT_MAX);
  localparam logic signed [PW-1:0] MIN_P  = PW'(gn3_pkg::OUT_MIN);

  // Rescale a product by 2^F, round to nearest with ties away from zero.
  function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] m;
    logic signed [PW-1:0] r;
    m = p[PW-1] ? -p : p;
    r = (m + HALF_P) >>> F;
    return p[PW-1] ? -r : r;
  endfunction

  function automatic logic signed [DW-1:0] grad(input logic [7:0] hv,
                                                input logic signed [F+1:0] x,
                                                input logic signed [F+1:0] y,
                                                input logic signed [F+1:0] z);
    logic [3:0]             h;
    logic signed [DW-1:0]   u;
    logic signed [DW-1:0]   v;
    h = hv[3:0];
    u = (h < 4'd8) ? DW'(x) : DW'(y);
    if (h < 4'd4) begin
      v = DW'(y);
    end else if (h == 4'd12 || h == 4'd14) begin
      v = DW'(x);
    end else begin
      v = DW'(z);
    end
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic logic signed [DW-1:0] blend(input logic [F:0] w,
                                                 input logic signed [DW-1:0] a,
                                                 input logic signed [DW-1:0] b);
    logic signed [PW-1:0] wp;
    logic signed [PW-1:0] diff;
    logic signed [PW-1:0] r;
    wp   = PW'({1'b0, w});
    diff = PW'(b) - PW'(a);
    r    = PW'(a) + rnd(wp * diff);
    return r[DW-1:0];
  endfunction

  // Stage handshake: a stage advances when empty or when the next one advances.
  logic [NS-1:0] v_r;
  logic [NS-1:0] adv;

  always_comb begin
    adv[NS-1] = !v_r[NS-1] || out_if.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  assign in_if.ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) begin
        v_r[0] <= in_if.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Stage 1: split coordinates, first hash level, fade polynomial and square.
  logic [F-1:0]           t_in [3];
  logic [7:0]             c_in [3];
  logic [7:0]             ha_nxt;
  logic [7:0]             hb_nxt;
  logic signed [SW-1:0]   s_nxt [3];
  logic [F:0]             t2_nxt [3];

  logic [7:0]             iz1_r;
  logic [7:0]             ha1_r;
  logic [7:0]             hb1_r;
  logic [F-1:0]           t1_r [3];
  logic signed [SW-1:0]   s1_r [3];
  logic [F:0]             t21_r [3];

  always_comb begin
    logic [31:0]          cw [3];
    logic signed [PW-1:0] tp;
    logic signed [PW-1:0] sp;
    logic signed [PW-1:0] sq;
    logic signed [PW-1:0] sf;
    cw[0] = {8'b0, in_if.x_coord} >> F;
    cw[1] = {8'b0, in_if.y_coord} >> F;
    cw[2] = {8'b0, in_if.z_coord} >> F;
    t_in[0] = in_if.x_coord[F-1:0];
    t_in[1] = in_if.y_coord[F-1:0];
    t_in[2] = in_if.z_coord[F-1:0];
    for (int a = 0; a < 3; a++) begin
      c_in[a]   = cw[a][7:0];
      tp        = PW'({1'b0, t_in[a]});
      sp        = PW'(6) * tp - PW'(15) * ONE_P;
      sf        = rnd(tp * sp) + PW'(10) * ONE_P;
      sq        = rnd(tp * tp);
      s_nxt[a]  = sf[SW-1:0];
      t2_nxt[a] = sq[F:0];
    end
    ha_nxt = gn3_pkg::PERM_ROM[c_in[0]] + c_in[1];
    hb_nxt = gn3_pkg::PERM_ROM[8'(c_in[0] + 8'd1)] + c_in[1];
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      iz1_r <= c_in[2];
      ha1_r <= ha_nxt;
      hb1_r <= hb_nxt;
      t1_r  <= t_in;
      s1_r  <= s_nxt;
      t21_r <= t2_nxt;
    end
  end

  // Stage 2: second hash level, cube of the fraction.
  logic [7:0]           hc_nxt [4];   // aa, ab, ba, bb
  logic [F:0]           t3_nxt [3];
  logic [7:0]           hc2_r [4];
  logic [F-1:0]         t2s_r [3];
  logic signed [SW-1:0] s2_r [3];
  logic [F:0]           t32_r [3];

  always_comb begin
    logic signed [PW-1:0] cb;
    hc_nxt[0] = gn3_pkg::PERM_ROM[ha1_r] + iz1_r;
    hc_nxt[1] = gn3_pkg::PERM_ROM[8'(ha1_r + 8'd1)] + iz1_r;
    hc_nxt[2] = gn3_pkg::PERM_ROM[hb1_r] + iz1_r;
    hc_nxt[3] = gn3_pkg::PERM_ROM[8'(hb1_r + 8'd1)] + iz1_r;
    for (int a = 0; a < 3; a++) begin
      cb        = rnd(PW'({1'b0, t21_r[a]}) * PW'({1'b0, t1_r[a]}));
      t3_nxt[a] = cb[F:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      hc2_r <= hc_nxt;
      t2s_r <= t1_r;
      s2_r  <= s1_r;
      t32_r <= t3_nxt;
    end
  end

  // Stage 3: gradient hashes, the eight corner dots and the fade weights.
  logic signed [DW-1:0] n_nxt [8];
  logic [F:0]           w_nxt [3];
  logic signed [DW-1:0] n3_r [8];
  logic [F:0]           w3_r [3];

  always_comb begin
    logic signed [F+1:0]  o0 [3];
    logic signed [F+1:0]  o1 [3];
    logic signed [PW-1:0] wr;
    for (int a = 0; a < 3; a++) begin
      o0[a] = (F+2)'({2'b00, t2s_r[a]});
      o1[a] = o0[a] - (F+2)'(ONE_P);
      wr    = rnd(PW'({1'b0, t32_r[a]}) * PW'(s2_r[a]));
      if (wr < 0) begin
        wr = '0;
      end else if (wr > ONE_P) begin
        wr = ONE_P;
      end
      w_nxt[a] = wr[F:0];
    end
    // Index bit 0 selects far x, bit 1 far y, bit 2 far z.
    n_nxt[0] = grad(gn3_pkg::PERM_ROM[hc2_r[0]], o0[0], o0[1], o0[2]);
    n_nxt[1] = grad(gn3_pkg::PERM_ROM[hc2_r[2]], o1[0], o0[1], o0[2]);
    n_nxt[2] = grad(gn3_pkg::PERM_ROM[hc2_r[1]], o0[0], o1[1], o0[2]);
    n_nxt[3] = grad(gn3_pkg::PERM_ROM[hc2_r[3]], o1[0], o1[1], o0[2]);
    n_nxt[4] = grad(gn3_pkg::PERM_ROM[8'(hc2_r[0] + 8'd1)], o0[0], o0[1], o1[2]);
    n_nxt[5] = grad(gn3_pkg::PERM_ROM[8'(hc2_r[2] + 8'd1)], o1[0], o0[1], o1[2]);
    n_nxt[6] = grad(gn3_pkg::PERM_ROM[8'(hc2_r[1] + 8'd1)], o0[0], o1[1], o1[2]);
    n_nxt[7] = grad(gn3_pkg::PERM_ROM[8'(hc2_r[3] + 8'd1)], o1[0], o1[1], o1[2]);
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      n3_r <= n_nxt;
      w3_r <= w_nxt;
    end
  end

  // Stage 4: blend along x.
  logic signed [DW-1:0] bx4_r [4];
  logic [F:0]           wv4_r;
  logic [F:0]           ww4_r;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      for (int i = 0; i < 4; i++) begin
        bx4_r[i] <= blend(w3_r[0], n3_r[2*i], n3_r[2*i+1]);
      end
      wv4_r <= w3_r[1];
      ww4_r <= w3_r[2];
    end
  end

  // Stage 5: blend along y.
  logic signed [DW-1:0] by5_r [2];
  logic [F:0]           ww5_r;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      by5_r[0] <= blend(wv4_r, bx4_r[0], bx4_r[1]);
      by5_r[1] <= blend(wv4_r, bx4_r[2], bx4_r[3]);
      ww5_r    <= ww4_r;
    end
  end

  // Stage 6: blend along z and saturate into the output register.
  logic signed [gn3_pkg::NOISE_W-1:0] res_r;
  logic signed [gn3_pkg::NOISE_W-1:0] res_nxt;

  always_comb begin
    logic signed [PW-1:0] rp;
    rp = PW'(blend(ww5_r, by5_r[0], by5_r[1]));
    if (rp > MAX_P) begin
      rp = MAX_P;
    end else if (rp < MIN_P) begin
      rp = MIN_P;
    end
    res_nxt = rp[gn3_pkg::NOISE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      res_r <= res_nxt;
    end
  end

  assign out_if.valid       = v_r[NS-1];
  assign out_if.noise_value = res_r;

  `GN3_ASSERT(a_accept_fills, in_if.valid && in_if.ready |=> v_r[0], "accepted item lost at entry")
  `GN3_ASSERT(a_full_stalls, (&v_r) && !out_if.ready |-> !in_if.ready, "item taken into full pipe")
  `GN3_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> v_r == '0, "pipeline not empty after reset")

endmodule

### test/gradient_noise_3d_tb.sv
`timescale 1ns / 1ps

module gradient_noise_3d_tb;

  localparam int FB = gn3_pkg::FRAC_BITS_DEF;
  localparam longint ONE = 64'sd1 <<< FB;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  gn3_in_if  in_ch ();
  gn3_out_if out_ch ();

  gradient_noise_3d i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch.sink),
    .out_if(out_ch.source)
  );

  always #10 clk = ~clk;

  // Expected noise values, oldest first
  logic signed [gn3_pkg::NOISE_W-1:0] noise_due[$];
  int mismatches = 0;
  int sink_mode = 0;  // 0: random stalls, 1: never stall
  int stall_left = 0;

  // Fixed-point product, rescaled and rounded half away from zero
  function automatic longint fx_prod(longint a, longint b);
    longint p;
    longint m;
    p = a * b;
    m = (p < 0) ? -p : p;
    m = (m + (64'sd1 <<< (FB - 1))) >>> FB;
    return (p < 0) ? -m : m;
  endfunction

  // Quintic fade weight, clamped to [0, ONE]
  function automatic longint fade(longint t);
    longint s;
    longint t3;
    longint w;
    s = fx_prod(t, 6 * t - 15 * ONE) + 10 * ONE;
    t3 = fx_prod(fx_prod(t, t), t);
    w = fx_prod(t3, s);
    if (w < 0) w = 0;
    if (w > ONE) w = ONE;
    return w;
  endfunction

  function automatic int unsigned perm(int unsigned idx);
    return gn3_pkg::PERM_ROM[idx & 255];
  endfunction

  function automatic longint grad_dot(int unsigned hv, longint x, longint y, longint z);
    int unsigned h;
    longint u;
    longint v;
    h = hv & 15;
    u = (h < 8) ? x : y;
    v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
    return ((h & 1) ? -u : u) + ((h & 2) ? -v : v);
  endfunction

  function automatic longint lerp(longint w, longint a, longint b);
    return a + fx_prod(w, b - a);
  endfunction

  function automatic logic signed [gn3_pkg::NOISE_W-1:0] noise_at(
      logic [gn3_pkg::COORD_W-1:0] cx,
      logic [gn3_pkg::COORD_W-1:0] cy,
      logic [gn3_pkg::COORD_W-1:0] cz);
    int unsigned ix, iy, iz, ha, hb, haa, hab, hba, hbb;
    longint x0, y0, z0, x1, y1, z1, wu, wv, ww, nz, fz, r;
    ix = (cx >> FB) & 255;
    iy = (cy >> FB) & 255;
    iz = (cz >> FB) & 255;
    x0 = cx & ((1 << FB) - 1);
    y0 = cy & ((1 << FB) - 1);
    z0 = cz & ((1 << FB) - 1);
    x1 = x0 - ONE;
    y1 = y0 - ONE;
    z1 = z0 - ONE;
    wu = fade(x0);
    wv = fade(y0);
    ww = fade(z0);
    ha = perm(ix) + iy;
    hb = perm(ix + 1) + iy;
    haa = perm(ha) + iz;
    hab = perm(ha + 1) + iz;
    hba = perm(hb) + iz;
    hbb = perm(hb + 1) + iz;
    nz = lerp(wv, lerp(wu, grad_dot(perm(haa), x0, y0, z0), grad_dot(perm(hba), x1, y0, z0)),
                  lerp(wu, grad_dot(perm(hab), x0, y1, z0), grad_dot(perm(hbb), x1, y1, z0)));
    fz = lerp(wv, lerp(wu, grad_dot(perm(haa + 1), x0, y0, z1),
                           grad_dot(perm(hba + 1), x1, y0, z1)),
                  lerp(wu, grad_dot(perm(hab + 1), x0, y1, z1),
                           grad_dot(perm(hbb + 1), x1, y1, z1)));
    r = lerp(ww, nz, fz);
    if (r > gn3_pkg::OUT_MAX) r = gn3_pkg::OUT_MAX;
    if (r < gn3_pkg::OUT_MIN) r = gn3_pkg::OUT_MIN;
    return r[gn3_pkg::NOISE_W-1:0];
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Present one point and hold it until accepted; valid stays high for a following item
  task automatic send_point(logic [gn3_pkg::COORD_W-1:0] x, logic [gn3_pkg::COORD_W-1:0] y,
                            logic [gn3_pkg::COORD_W-1:0] z, bit gaps = 1'b1);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.x_coord <= x;
    in_ch.y_coord <= y;
    in_ch.z_coord <= z;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    noise_due.push_back(noise_at(x, y, z));
    @(negedge clk);
  endtask

  // Drive the result ready at each falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (sink_mode == 1) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 99) < 3) begin
      stall_left = $urandom_range(10, 40);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) < 65);
    end
  end

  // Compare each accepted result against the oldest expectation
  always @(posedge clk) begin
    logic signed [gn3_pkg::NOISE_W-1:0] want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (noise_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result noise_value=%0d", out_ch.noise_value);
      end else begin
        want = noise_due.pop_front();
        if (out_ch.noise_value !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("noise_value mismatch: expected %0d, got %0d", want, out_ch.noise_value);
        end
      end
    end
  end

  // Drop valid, then wait until every expected result has come
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (noise_due.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Lattice points, fraction extremes and cell wrap
  task automatic test_directed();
    send_point(24'h000000, 24'h000000, 24'h000000);
    send_point(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_point(24'h00FFFF, 24'h00FFFF, 24'h00FFFF);
    send_point(24'hFF0000, 24'hFF0000, 24'hFF0000);
    send_point(24'h008000, 24'h008000, 24'h008000);
    send_point(24'h000001, 24'hFFFFFF, 24'h000000);
    send_point(24'hFFFFFF, 24'h000001, 24'h7FFFFF);
    send_point(24'h800000, 24'h7FFFFF, 24'hAAAAAA);
    send_point(24'h555555, 24'hAAAAAA, 24'h555555);
    send_point(24'hFF8000, 24'h018000, 24'hFEC000);
    send_point(24'h123456, 24'h654321, 24'hABCDEF);
    for (int i = 0; i < 10; i++)
      send_point({8'($urandom_range(0, 255)), 16'h4000}, {8'($urandom_range(0, 255)), 16'hC000},
                 {8'($urandom_range(0, 255)), 16'h8000});
  endtask

  // Back-to-back items with an always-ready sink
  task automatic test_full_rate();
    sink_mode = 1;
    for (int i = 0; i < 200; i++) send_point(24'($urandom), 24'($urandom), 24'($urandom), 1'b0);
    wait_drained();
    sink_mode = 0;
  endtask

  // Random points under random stalls; pause once until the pipe is empty
  task automatic test_random();
    for (int i = 0; i < 1630; i++) begin
      if (i == 800) begin
        wait_drained();
      end
      send_point(24'($urandom), 24'($urandom), 24'($urandom));
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.x_coord = '0;
    in_ch.y_coord = '0;
    in_ch.z_coord = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_full_rate();
    test_random();
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && noise_due.size() == 0) begin
      $display("gradient_noise_3d regression: pass");
    end else begin
      $display("gradient_noise_3d regression: fail");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run
  initial begin
    #20ms;
    $display("gradient_noise_3d regression: fail");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/gn3_pkg.sv
rtl/core/gn3_if.sv
rtl/core/gradient_noise_3d.sv
test/gradient_noise_3d_tb.sv
